// ===== design/swt_pkg.sv =====
// Shared types and byte constants for the shell word tokenizer.
// No dependencies; used by swt_lexer, swt_out_stage and the top level.

package swt_pkg;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;  // TAB..CR are whitespace
  localparam logic [7:0] ChCr        = 8'h0D;

  typedef enum logic [2:0] {
    MODE_PLAIN  = 3'd0,
    MODE_SQ     = 3'd1,
    MODE_DQ     = 3'd2,
    MODE_ESC    = 3'd3,
    MODE_DQ_ESC = 3'd4
  } mode_e;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       word_end;
    logic       input_end;
  } result_t;

endpackage

// ===== design/swt_lexer.sv =====
// Lexer state (quote/escape mode, word-nonempty flag) and the per-byte step logic.
// Depends on swt_pkg.

module swt_lexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,  // byte in the input register moves on
  input  logic [7:0]        in_byte_i,
  input  logic              last_i,
  output swt_pkg::result_t  res_o
);

  swt_pkg::mode_e mode_q, mode_d;
  logic           nonempty_q, nonempty_d;

  logic       is_ws;
  logic       emit;
  logic       wend;
  logic       nonempty_tmp;
  logic [7:0] ob;

  assign is_ws = (in_byte_i == swt_pkg::ChSpace) ||
                 ((in_byte_i >= swt_pkg::ChTab) && (in_byte_i <= swt_pkg::ChCr));

  always_comb begin
    mode_d       = mode_q;
    nonempty_tmp = nonempty_q;
    emit         = 1'b0;
    wend         = 1'b0;
    ob           = 8'h00;
    unique case (mode_q)
      swt_pkg::MODE_SQ: begin
        if (in_byte_i == swt_pkg::ChSquote) begin
          mode_d = swt_pkg::MODE_PLAIN;
        end else begin
          emit = 1'b1;
        end
      end
      swt_pkg::MODE_DQ: begin
        if (in_byte_i == swt_pkg::ChDquote) begin
          mode_d = swt_pkg::MODE_PLAIN;
        end else if (in_byte_i == swt_pkg::ChBackslash && !last_i) begin
          mode_d = swt_pkg::MODE_DQ_ESC;
        end else begin
          emit = 1'b1;
        end
      end
      swt_pkg::MODE_ESC: begin
        emit   = 1'b1;
        mode_d = swt_pkg::MODE_PLAIN;
      end
      swt_pkg::MODE_DQ_ESC: begin
        emit   = 1'b1;
        mode_d = swt_pkg::MODE_DQ;
      end
      default: begin
        mode_d = swt_pkg::MODE_PLAIN;
        if (is_ws) begin
          if (nonempty_q) begin
            wend         = 1'b1;
            nonempty_tmp = 1'b0;
          end
        end else if (in_byte_i == swt_pkg::ChSquote) begin
          mode_d = swt_pkg::MODE_SQ;
        end else if (in_byte_i == swt_pkg::ChDquote) begin
          mode_d = swt_pkg::MODE_DQ;
        end else if (in_byte_i == swt_pkg::ChBackslash && !last_i) begin
          mode_d = swt_pkg::MODE_ESC;
        end else begin
          emit = 1'b1;
        end
      end
    endcase

    if (emit) begin
      ob           = in_byte_i;
      nonempty_tmp = 1'b1;
    end
    nonempty_d = nonempty_tmp;

    // final byte closes any open word and returns to reset state
    if (last_i) begin
      if (nonempty_tmp) wend = 1'b1;
      mode_d     = swt_pkg::MODE_PLAIN;
      nonempty_d = 1'b0;
    end
  end

  assign res_o.out_byte   = ob;
  assign res_o.byte_valid = emit;
  assign res_o.word_end   = wend;
  assign res_o.input_end  = last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= swt_pkg::MODE_PLAIN;
      nonempty_q <= 1'b0;
    end else if (advance_i) begin
      mode_q     <= mode_d;
      nonempty_q <= nonempty_d;
    end
  end

endmodule

// ===== design/swt_out_stage.sv =====
// Result register with valid/ready handshake toward the output stream.
// Depends on swt_pkg.

module swt_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,    // new result written this cycle
  input  swt_pkg::result_t  res_i,
  input  logic              ready_i,   // downstream takes the word
  output logic              valid_o,
  output logic              free_o,    // register can take a result this cycle
  output swt_pkg::result_t  res_o
);

  logic             valid_q, valid_d;
  swt_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== design/shell_word_tokenizer_unit.sv =====
// Shell word tokenizer top level: input register, lexer step, result register.
// Depends on swt_pkg, swt_lexer and swt_out_stage.
//
//   Stream   Dir  tdata                tuser                      tlast
//   s_axis   in   in_byte[7:0]         -                          last_byte
//   m_axis   out  out_byte[7:0]        byte_valid[0], word_end[1] input_end
//
// One byte per cycle sustained while m_axis_tready stays high; an accepted byte
// passes from the input register through the lexer step into the result register,
// from which it leaves on m_axis.
// The lexer mode and word-nonempty registers feed back into the lexer step.
// Reset clears the valid flags and the lexer state (plain mode, empty word).
// A stall on m_axis holds the result register; the input register still
// takes a byte while it is empty, then s_axis_tready drops.

module shell_word_tokenizer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] word_end
  output logic       m_axis_tlast
);

  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic             advance;
  logic             out_free;
  logic             in_take;
  swt_pkg::result_t step_res;
  swt_pkg::result_t out_res;

  // byte leaves the input register when the result register has room
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_take || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  swt_lexer u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .in_byte_i (in_byte_q),
    .last_i    (in_last_q),
    .res_o     (step_res)
  );

  swt_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (step_res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .free_o  (out_free),
    .res_o   (out_res)
  );

  assign m_axis_tdata    = out_res.out_byte;
  assign m_axis_tuser[0] = out_res.byte_valid;
  assign m_axis_tuser[1] = out_res.word_end;
  assign m_axis_tlast    = out_res.input_end;

  // no byte appended means the data byte reads zero
  a_zero_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
    else $error("out_byte nonzero without byte_valid");

  // mid-input word end comes from whitespace, which appends nothing
  a_ws_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] && !m_axis_tlast |-> !m_axis_tuser[0])
    else $error("word_end with byte before final byte");

  // a held input byte blocks new input
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> !s_axis_tready)
    else $error("input accepted while input register stalled");

  // a stalled result stays valid
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

endmodule
